[hdl/can_id_show_hide_filter_defines.svh]
// Assertion macros for the CAN identifier show/hide filter checker.
// Depends on nothing; included by the checker file.
`ifndef CAN_ID_SHOW_HIDE_FILTER_DEFINES_SVH
`define CAN_ID_SHOW_HIDE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CIDF_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cidf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CIDF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("cidf check failed");

`endif

[hdl/cidf_pkg.sv]
// Shared constants for the CAN identifier show/hide filter.
// No dependencies; used by the top level and the checker.
package cidf_pkg;

    localparam int ID_W           = 29;
    localparam int LIST_DEPTH_DEF = 16;

    localparam logic [1:0] OP_CHECK    = 2'd0;
    localparam logic [1:0] OP_ADD_SHOW = 2'd1;
    localparam logic [1:0] OP_ADD_HIDE = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd1;
    localparam logic [1:0] MODE_SHOW = 2'd2;
    localparam logic [1:0] MODE_HIDE = 2'd3;

endpackage

[hdl/can_id_show_hide_filter.sv]
// CAN identifier acceptance filter with a show list and a hide list.
// Depends on cidf_pkg. Each list is a synchronous RAM with a registered read.
//
// One item is handled at a time and each item yields one result item. Add,
// clear and checks that need no list lookup (pass-all mode or an empty list)
// deliver their result in the cycle after acceptance, and the next item can be
// taken in that same cycle. A check that looks up a list walks that list's
// RAM one entry per cycle, stopping early on the first match, and the input
// stalls for the whole walk, since each list RAM has a single read port; the
// next item can be taken in the same cycle as its result appears. A finished
// result waits in the output register while out_stall is high, and the input
// stalls until it is taken. Writes to force_mode are taken at any cycle and
// apply to the next check item.
module can_id_show_hide_filter
    import cidf_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      opcode,
    input  logic [ID_W-1:0] can_id,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            visible,
    output logic            status,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_wdata
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic [ID_W-1:0] show_mem [LIST_DEPTH];
    logic [ID_W-1:0] hide_mem [LIST_DEPTH];

    logic             state_reg,      state_next;
    logic [1:0]       force_mode_reg;
    logic [CNT_W-1:0] show_cnt_reg,   show_cnt_next;
    logic [CNT_W-1:0] hide_cnt_reg,   hide_cnt_next;
    logic [CNT_W-1:0] scan_cnt_reg,   scan_cnt_next;
    logic [CNT_W-1:0] rd_idx_reg,     rd_idx_next;
    logic             cmp_valid_reg,  cmp_valid_next;
    logic             sel_hide_reg,   sel_hide_next;
    logic [ID_W-1:0]  id_reg,         id_next;
    logic             out_valid_reg,  out_valid_next;
    logic             visible_reg,    visible_next;
    logic             status_reg,     status_next;
    logic [ID_W-1:0]  show_rd_reg;
    logic [ID_W-1:0]  hide_rd_reg;

    logic             in_accept;
    logic [1:0]       mode_eff;
    logic             show_we;
    logic             hide_we;
    logic             rd_en;
    logic             produce;
    logic             res_visible;
    logic             res_status;
    logic [ID_W-1:0]  rd_data;
    logic             hit;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign status    = status_reg;

    assign rd_data = sel_hide_reg ? hide_rd_reg : show_rd_reg;
    assign hit     = cmp_valid_reg && (rd_data == id_reg);

    // Resolve auto mode from the list fill counts.
    always_comb
    begin
        case (force_mode_reg)
            MODE_AUTO:
            begin
                if (show_cnt_reg == '0 && hide_cnt_reg == '0)
                    mode_eff = MODE_PASS;
                else if (show_cnt_reg != '0)
                    mode_eff = MODE_SHOW;
                else
                    mode_eff = MODE_HIDE;
            end
            default: mode_eff = force_mode_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        show_cnt_next  = show_cnt_reg;
        hide_cnt_next  = hide_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        sel_hide_next  = sel_hide_reg;
        id_next        = id_reg;
        show_we        = 1'b0;
        hide_we        = 1'b0;
        rd_en          = 1'b0;
        produce        = 1'b0;
        res_visible    = 1'b0;
        res_status     = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (opcode)
                        OP_CHECK:
                        begin
                            case (mode_eff)
                                MODE_SHOW:
                                begin
                                    if (show_cnt_reg == '0)
                                        produce = 1'b1;
                                    else
                                    begin
                                        state_next     = ST_SCAN;
                                        sel_hide_next  = 1'b0;
                                        scan_cnt_next  = show_cnt_reg;
                                        rd_idx_next    = '0;
                                        cmp_valid_next = 1'b0;
                                        id_next        = can_id;
                                    end
                                end
                                MODE_HIDE:
                                begin
                                    if (hide_cnt_reg == '0)
                                    begin
                                        produce     = 1'b1;
                                        res_visible = 1'b1;
                                    end
                                    else
                                    begin
                                        state_next     = ST_SCAN;
                                        sel_hide_next  = 1'b1;
                                        scan_cnt_next  = hide_cnt_reg;
                                        rd_idx_next    = '0;
                                        cmp_valid_next = 1'b0;
                                        id_next        = can_id;
                                    end
                                end
                                default:
                                begin
                                    produce     = 1'b1;
                                    res_visible = 1'b1;
                                end
                            endcase
                        end
                        OP_ADD_SHOW:
                        begin
                            produce = 1'b1;
                            if (show_cnt_reg < DEPTH_C)
                            begin
                                show_we       = 1'b1;
                                show_cnt_next = show_cnt_reg + 1'b1;
                            end
                            else
                                res_status = 1'b1;
                        end
                        OP_ADD_HIDE:
                        begin
                            produce = 1'b1;
                            if (hide_cnt_reg < DEPTH_C)
                            begin
                                hide_we       = 1'b1;
                                hide_cnt_next = hide_cnt_reg + 1'b1;
                            end
                            else
                                res_status = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            produce       = 1'b1;
                            show_cnt_next = '0;
                            hide_cnt_next = '0;
                        end
                        default: produce = 1'b1;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Stop on the first match or once the last read is compared.
                if (hit || (rd_idx_reg == scan_cnt_reg && !cmp_valid_reg))
                begin
                    produce        = 1'b1;
                    res_visible    = sel_hide_reg ? !hit : hit;
                    state_next     = ST_IDLE;
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    cmp_valid_next = rd_idx_reg < scan_cnt_reg;
                    if (rd_idx_reg < scan_cnt_reg)
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        visible_next = visible_reg;
        status_next  = status_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
            visible_next   = res_visible;
            status_next    = res_status;
        end
    end

    // Show list RAM: write at the fill count, read at the scan index.
    always_ff @(posedge clk)
    begin
        if (show_we)
            show_mem[show_cnt_reg[IDX_W-1:0]] <= can_id;
        if (rd_en)
            show_rd_reg <= show_mem[rd_idx_reg[IDX_W-1:0]];
    end

    // Hide list RAM.
    always_ff @(posedge clk)
    begin
        if (hide_we)
            hide_mem[hide_cnt_reg[IDX_W-1:0]] <= can_id;
        if (rd_en)
            hide_rd_reg <= hide_mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        visible_reg <= visible_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            force_mode_reg <= MODE_AUTO;
            show_cnt_reg   <= '0;
            hide_cnt_reg   <= '0;
            scan_cnt_reg   <= '0;
            rd_idx_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            sel_hide_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            show_cnt_reg  <= show_cnt_next;
            hide_cnt_reg  <= hide_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            sel_hide_reg  <= sel_hide_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                force_mode_reg <= cfg_wdata;
        end
    end

endmodule

[hdl/cidf_checker.sv]
// Port-level checker for the CAN identifier show/hide filter.
// Depends on cidf_pkg and can_id_show_hide_filter_defines.svh; bound to the top level.
`include "can_id_show_hide_filter_defines.svh"

module cidf_checker
    import cidf_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic [1:0]      opcode,
    input logic            out_valid,
    input logic            out_stall,
    input logic            visible,
    input logic            status
);

    logic in_acc;
    logic is_add;
    logic is_clear;
    logic out_wait;

    assign in_acc   = in_valid && !in_stall;
    assign is_add   = (opcode == OP_ADD_SHOW) || (opcode == OP_ADD_HIDE);
    assign is_clear = (opcode == OP_CLEAR);
    assign out_wait = out_valid && out_stall;

    // Hold a stalled result item.
    `CIDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable({visible, status}))
    // A dropped add never reports a pass.
    `CIDF_ASSERT_NOW(a_status_excl, clk, rst_n, out_valid && status, !visible)
    // Clear answers in the next cycle with an all-zero item.
    `CIDF_ASSERT_NEXT(a_clear_result, clk, rst_n, in_acc && is_clear, out_valid && !(visible || status))
    // Add answers in the next cycle and never shows visible.
    `CIDF_ASSERT_NEXT(a_add_result, clk, rst_n, in_acc && is_add, out_valid && !visible)

endmodule

bind can_id_show_hide_filter cidf_checker u_cidf_checker (.*);

[bench/can_id_show_hide_filter_tb.sv]
// Testbench for can_id_show_hide_filter: check, add and clear items under random idling.
// Verdicts are predicted from a behavioral copy of both ID lists and the mode register.
// Depends on cidf_pkg and the filter RTL.
module can_id_show_hide_filter_tb;
    import cidf_pkg::*;

    localparam int DEPTH       = LIST_DEPTH_DEF;
    localparam int SETTLE      = DEPTH + 8;
    localparam int LONG_HOLD   = 160;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 53;
    localparam int POOL_MAX    = 32;

    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef struct packed
    {
        logic visible;
        logic status;
    } verdict_t;

    localparam verdict_t V_NONE = 2'b00;
    localparam verdict_t V_HIT  = 2'b10;
    localparam verdict_t V_FULL = 2'b01;

    typedef struct
    {
        logic [1:0]      mode;
        logic [1:0]      op;
        logic [ID_W-1:0] id;
        int              rep;
        int              stride;
        bit              typed;
        verdict_t        want;
    } dir_row_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [1:0]      opcode;
    logic [ID_W-1:0] can_id;
    logic            out_valid;
    logic            out_stall;
    logic            visible;
    logic            status;
    logic            cfg_we;
    logic [1:0]      cfg_wdata;

    // predicted filter state
    logic [ID_W-1:0] show_list [DEPTH];
    logic [ID_W-1:0] hide_list [DEPTH];
    int              show_used;
    int              hide_used;
    logic [1:0]      mode_now;

    verdict_t        verdicts_due [$];
    logic [ID_W-1:0] id_pool [$];
    int              mismatches;
    int              gap_next;
    bit              offering;
    bit              send_steady;
    bit              recv_steady;
    bit              long_hold_req;

    logic [1:0] mode_codes [4] = '{MODE_AUTO, MODE_PASS, MODE_SHOW, MODE_HIDE};
    logic [1:0] op_codes [4]   = '{OP_CHECK, OP_ADD_SHOW, OP_ADD_HIDE, OP_CLEAR};

    dir_row_t dir_rows [19] = '{
        '{MODE_AUTO, OP_CHECK,    '0,           1,  0, 1'b1, V_HIT},
        '{MODE_AUTO, OP_CHECK,    ID_MAX,       1,  0, 1'b1, V_HIT},
        '{MODE_AUTO, OP_ADD_HIDE, ID_MAX,       2,  0, 1'b1, V_NONE},
        '{MODE_AUTO, OP_CHECK,    ID_MAX,       1,  0, 1'b1, V_NONE},
        '{MODE_AUTO, OP_CHECK,    '0,           1,  0, 1'b1, V_HIT},
        '{MODE_HIDE, OP_CHECK,    29'h1FFFFFFE, 1,  0, 1'b0, V_NONE},
        '{MODE_AUTO, OP_ADD_SHOW, '0,           1,  0, 1'b1, V_NONE},
        '{MODE_AUTO, OP_CHECK,    '0,           1,  0, 1'b1, V_HIT},
        '{MODE_AUTO, OP_CHECK,    ID_MAX,       1,  0, 1'b1, V_NONE},
        '{MODE_PASS, OP_CHECK,    29'h0AAAAAAA, 1,  0, 1'b1, V_HIT},
        '{MODE_HIDE, OP_CHECK,    ID_MAX,       1,  0, 1'b1, V_NONE},
        '{MODE_AUTO, OP_CLEAR,    ID_MAX,       1,  0, 1'b1, V_NONE},
        '{MODE_SHOW, OP_CHECK,    '0,           1,  0, 1'b1, V_NONE},
        '{MODE_HIDE, OP_CHECK,    ID_MAX,       1,  0, 1'b1, V_HIT},
        '{MODE_SHOW, OP_ADD_SHOW, 29'h15555555, 16, 1, 1'b0, V_NONE},
        '{MODE_SHOW, OP_ADD_SHOW, 29'h0AAAAAAA, 1,  0, 1'b1, V_FULL},
        '{MODE_SHOW, OP_CHECK,    29'h15555564, 1,  0, 1'b0, V_NONE},
        '{MODE_SHOW, OP_CHECK,    29'h0AAAAAAA, 1,  0, 1'b1, V_NONE},
        '{MODE_AUTO, OP_CLEAR,    '0,           1,  0, 1'b1, V_NONE}
    };

    can_id_show_hide_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .can_id    (can_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .visible   (visible),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit id_listed(bit hide_side, logic [ID_W-1:0] id);
        int n;
        n = hide_side ? hide_used : show_used;
        for (int i = 0; i < n; i++)
            if ((hide_side ? hide_list[i] : show_list[i]) == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic verdict_t filter_apply(logic [1:0] op, logic [ID_W-1:0] id);
        verdict_t   v;
        logic [1:0] m;
        v = V_NONE;
        case (op)
            OP_CHECK:
            begin
                m = mode_now;
                // auto mode: an empty pair passes all, a nonempty show list wins
                if (m == MODE_AUTO)
                    m = (show_used == 0 && hide_used == 0) ? MODE_PASS :
                        (show_used != 0) ? MODE_SHOW : MODE_HIDE;
                case (m)
                    MODE_PASS: v.visible = 1'b1;
                    MODE_SHOW: v.visible = id_listed(1'b0, id);
                    default:   v.visible = !id_listed(1'b1, id);
                endcase
            end
            OP_ADD_SHOW:
            begin
                if (show_used >= DEPTH)
                    v.status = 1'b1;
                else
                begin
                    show_list[show_used] = id;
                    show_used++;
                end
            end
            OP_ADD_HIDE:
            begin
                if (hide_used >= DEPTH)
                    v.status = 1'b1;
                else
                begin
                    hide_list[hide_used] = id;
                    hide_used++;
                end
            end
            default:
            begin
                show_used = 0;
                hide_used = 0;
            end
        endcase
        return v;
    endfunction

    function automatic int idle_draw(bit steady);
        if (steady)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 1);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: id &= ID_W'(11'h7FF);
            default:
            begin
                // reuse a listed ID, sometimes one bit off for a near miss
                if (id_pool.size() != 0)
                begin
                    id = id_pool[$urandom_range(0, id_pool.size() - 1)];
                    if ($urandom_range(0, 3) == 0)
                        id[$urandom_range(0, ID_W - 1)] ^= 1'b1;
                end
            end
        endcase
        return id;
    endfunction

    function automatic logic [1:0] pick_op(int kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            1: return r < 40 ? OP_ADD_SHOW : r < 45 ? OP_ADD_HIDE : r < 47 ? OP_CLEAR : OP_CHECK;
            2: return r < 40 ? OP_ADD_HIDE : r < 43 ? OP_ADD_SHOW : r < 45 ? OP_CLEAR : OP_CHECK;
            3: return op_codes[$urandom_range(0, 3)];
            default: return r < 15 ? OP_ADD_SHOW : r < 30 ? OP_ADD_HIDE : r < 34 ? OP_CLEAR : OP_CHECK;
        endcase
    endfunction

    function automatic void note_bad(string what, logic [1:0] want_v, logic [1:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0b, got %0b", $realtime, what, want_v, got_v);
    endfunction

    task automatic send_item(logic [1:0] op, logic [ID_W-1:0] id, bit typed, verdict_t want);
        verdict_t v;
        repeat (gap_next) @(posedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        can_id   <= id;
        do @(posedge clk); while (!(in_valid && !in_stall));
        v = filter_apply(op, id);
        verdicts_due = {verdicts_due, (typed ? want : v)};
        if (op == OP_ADD_SHOW || op == OP_ADD_HIDE)
        begin
            id_pool = {id_pool, id};
            if (id_pool.size() > POOL_MAX)
                void'(id_pool.pop_front());
        end
        // keep valid up only when the next item follows at once
        gap_next = idle_draw(send_steady);
        offering = (gap_next == 0);
        if (!offering)
            in_valid <= 1'b0;
    endtask

    task automatic settle_idle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_now = m;
    endtask

    task automatic take_verdict();
        verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            note_bad("unexpected result", V_NONE, {visible, status});
            return;
        end
        want = verdicts_due.pop_front();
        if ({visible, status} !== want)
            note_bad("visible/status", want, {visible, status});
    endtask

    // result side: stall a random number of cycles, then take one item
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = idle_draw(recv_steady);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            take_verdict();
        end
    end

    initial
    begin
        int kind;
        int burst_left;
        bit phase_steady;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_CHECK;
        can_id    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= MODE_AUTO;
        show_used     = 0;
        hide_used     = 0;
        mode_now      = MODE_AUTO;
        mismatches    = 0;
        gap_next      = 0;
        offering      = 1'b0;
        send_steady   = 1'b0;
        recv_steady   = 1'b0;
        long_hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].mode != mode_now)
                set_mode(dir_rows[r].mode);
            for (int k = 0; k < dir_rows[r].rep; k++)
                send_item(dir_rows[r].op, dir_rows[r].id + ID_W'(k * dir_rows[r].stride),
                          dir_rows[r].typed, dir_rows[r].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            phase_steady = (p % 4 == 3);
            recv_steady  = (p % 4 == 2);
            set_mode(mode_codes[p < 4 ? p : $urandom_range(0, 3)]);
            kind = $urandom_range(0, 3);
            // hold the result side off while items keep coming, to back up the input
            burst_left = 0;
            if (p == 5 || p == 11)
            begin
                long_hold_req = 1'b1;
                burst_left = 12;
            end
            send_steady = phase_steady || burst_left > 0;
            if (kind != 3 && $urandom_range(0, 3) != 0)
                send_item(OP_CLEAR, pick_id(), 1'b0, V_NONE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left > 0)
                    burst_left--;
                send_steady = phase_steady || burst_left > 0;
                send_item(pick_op(kind), pick_id(), 1'b0, V_NONE);
            end
        end

        settle_idle();
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
